/* src/assert_macros.svh */
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/bba_pkg.sv */
// Shared types and constants for the buddy block allocator.
`default_nettype none
package bba_pkg;
    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_SPLIT = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_CHK,
        S_DONE,
        S_OUT
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic start;     // load item, go to root
        logic rd;        // issue read of current node
        logic eval;      // act on read data
        logic chk;       // merge check step (children read)
        logic finish;    // latch the result
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic next_read; // a node read is needed
        logic next_chk;  // a merge check is needed
        logic done;      // walk finished
    } t_sts;
endpackage
`default_nettype wire

/* src/bba_ram.sv */
// Generic RAM with one write port and one registered read port.
`default_nettype none
module bba_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* src/bba_ctrl.sv */
// Controller state machine sequencing the tree walk.
`default_nettype none
module bba_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_stall,
    input  wire logic          i_clear_busy,
    input  wire bba_pkg::t_sts i_sts,
    output bba_pkg::t_cmd      o_cmd,
    output logic               o_stall,
    output logic               o_valid
);
    import bba_pkg::*;
    `include "assert_macros.svh"

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid && !i_clear_busy) n_state = S_READ;
            S_READ: n_state = S_EVAL;
            S_EVAL, S_CHK: begin
                // no flag set: return step at the parent, no read needed
                if (i_sts.done)           n_state = S_DONE;
                else if (i_sts.next_chk)  n_state = S_CHK;
                else if (i_sts.next_read) n_state = S_READ;
                else                      n_state = S_EVAL;
            end
            S_DONE: n_state = S_OUT;
            S_OUT:  if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_stall     = i_clear_busy;
                o_cmd.start = i_valid && !i_clear_busy;
            end
            S_READ: o_cmd.rd   = 1'b1;
            S_EVAL: o_cmd.eval = 1'b1;
            S_CHK:  o_cmd.chk  = 1'b1;
            S_DONE: o_cmd.finish = 1'b1;
            S_OUT:  o_valid = 1'b1;
            default: ;
        endcase
    end

    `ASSERT_IMPL(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0(o_cmd), "multiple commands")
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result dropped")
    `ASSERT_IMPL(a_busy_stall, i_clk, i_rst_n, r_state != S_IDLE, o_stall, "input while busy")
endmodule
`default_nettype wire

/* src/bba_dp.sv */
// Datapath: node store, walk position, used total and result registers.
`default_nettype none
module bba_dp #(
    parameter int LEVELS      = 6,
    parameter int BLOCK_BYTES = 1024
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire bba_pkg::t_cmd i_cmd,
    input  wire logic          i_mode,
    input  wire logic [23:0]   i_request_bytes,
    input  wire logic [15:0]   i_block_offset,
    output bba_pkg::t_sts      o_sts,
    output logic               o_clear_busy,
    output logic               o_success,
    output logic [15:0]        o_granted_offset,
    output logic [16:0]        o_used_bytes
);
    import bba_pkg::*;
    `include "assert_macros.svh"

    localparam int NODES = (2 << LEVELS) - 1;
    localparam int AW    = $clog2(NODES + 1);
    localparam int DW    = $clog2(LEVELS + 1);
    localparam int BW    = LEVELS + $clog2(BLOCK_BYTES) + 2;
    localparam int RW    = (BW > 24) ? BW : 24;
    localparam int OW    = (BW > 16) ? BW : 16;
    localparam logic [BW-1:0] POOL_BYTES = BW'(BLOCK_BYTES) << LEVELS;

    // Walk position: heap index, depth, node size and base offset. The path is
    // encoded in the index, so returning upward goes to the parent.
    logic [AW-1:0] r_node, n_node;
    logic [DW-1:0] r_depth, n_depth;
    logic [BW-1:0] r_size, n_size;
    logic [BW-1:0] r_base, n_base;
    logic          r_back, n_back;    // returned to r_node from a child
    logic          r_carry, n_carry;  // outcome of that child
    logic          r_right, n_right;  // that child was the right one
    logic          r_mode;
    logic [RW-1:0] r_req;
    logic [OW-1:0] r_off;
    logic          r_ok, n_ok;
    logic [BW-1:0] r_got, n_got;
    logic [16:0]   r_used, n_used;
    logic [1:0]    r_cphase, n_cphase; // merge check: read left, read right, decide
    logic [1:0]    r_lst;

    // Clearing pass.
    logic          r_clr;
    logic [AW-1:0] r_clr_addr;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [1:0]    wdata, rdata;

    bba_ram #(.WIDTH(2), .DEPTH(1 << AW)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic [BW-1:0] half;
    logic          is_leaf;
    logic [AW-1:0] lchild, rchild, parent;
    assign half    = r_size >> 1;
    assign is_leaf = (r_depth == DW'(LEVELS));
    assign lchild  = (r_node << 1) + AW'(1);
    assign rchild  = (r_node << 1) + AW'(2);
    assign parent  = (r_node - AW'(1)) >> 1;

    logic go_up, up_ok;

    always_comb begin
        o_sts    = '0;
        n_node   = r_node;
        n_depth  = r_depth;
        n_size   = r_size;
        n_base   = r_base;
        n_back   = r_back;
        n_carry  = r_carry;
        n_right  = r_right;
        n_ok     = r_ok;
        n_got    = r_got;
        n_used   = r_used;
        n_cphase = r_cphase;
        go_up    = 1'b0;
        up_ok    = 1'b0;
        we       = 1'b0;
        waddr    = r_node;
        wdata    = ST_FREE;
        raddr    = r_node;
        if (r_clr) begin
            we    = 1'b1;
            waddr = r_clr_addr;
        end else if (i_cmd.eval && !r_back) begin
            if (r_mode == MODE_ALLOC) begin
                if (rdata == ST_SPLIT && !is_leaf) begin
                    n_node = lchild; n_depth = r_depth + DW'(1); n_size = half;
                    o_sts.next_read = 1'b1;
                end else if (rdata != ST_FREE || r_req > RW'(r_size)) begin
                    go_up = 1'b1;
                end else if (is_leaf || r_req > RW'(half)) begin
                    we = 1'b1; wdata = ST_ALLOC;
                    n_used = r_used + 17'(r_size);
                    n_got  = r_base;
                    n_ok   = 1'b1;
                    o_sts.done = 1'b1;
                end else begin
                    we = 1'b1; wdata = ST_SPLIT;
                    n_node = lchild; n_depth = r_depth + DW'(1); n_size = half;
                    o_sts.next_read = 1'b1;
                end
            end else begin
                if (rdata == ST_FREE) begin
                    go_up = 1'b1;
                end else if (rdata == ST_SPLIT && !is_leaf) begin
                    n_node = lchild; n_depth = r_depth + DW'(1); n_size = half;
                    o_sts.next_read = 1'b1;
                end else if (OW'(r_base) == r_off) begin
                    we = 1'b1; wdata = ST_FREE;
                    n_used = r_used - 17'(r_size);
                    go_up = 1'b1; up_ok = 1'b1;
                end else begin
                    go_up = 1'b1;
                end
            end
        end else if (i_cmd.eval) begin
            // back at a split node: try the right child, else go up (alloc) or merge check (free)
            if (!r_right && !r_carry) begin
                n_node = rchild; n_depth = r_depth + DW'(1); n_size = half;
                n_base = r_base + half; n_back = 1'b0;
                o_sts.next_read = 1'b1;
            end else if (r_mode == MODE_ALLOC) begin
                go_up = 1'b1;
            end else begin
                n_cphase = 2'd0;
                o_sts.next_chk = 1'b1;
            end
        end else if (i_cmd.chk) begin
            raddr = (r_cphase == 2'd0) ? lchild : rchild;
            if (r_cphase == 2'd2) begin
                if (r_lst == ST_FREE && rdata == ST_FREE) begin
                    we = 1'b1; wdata = ST_FREE;
                end
                go_up = 1'b1; up_ok = r_carry;
            end else begin
                n_cphase = r_cphase + 2'd1;
                o_sts.next_chk = 1'b1;
            end
        end
        if (go_up) begin
            if (r_node == '0) begin
                n_ok = up_ok;
                o_sts.done = 1'b1;
            end else begin
                n_node  = parent;
                n_depth = r_depth - DW'(1);
                n_size  = r_size << 1;
                n_base  = r_node[0] ? r_base : r_base - r_size;
                n_back  = 1'b1;
                n_carry = up_ok;
                n_right = !r_node[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_used     <= '0;
            r_node     <= '0;
            r_depth    <= '0;
            r_size     <= '0;
            r_base     <= '0;
            r_back     <= 1'b0;
            r_carry    <= 1'b0;
            r_right    <= 1'b0;
            r_ok       <= 1'b0;
            r_got      <= '0;
            r_cphase   <= '0;
            r_lst      <= ST_FREE;
            r_mode     <= MODE_ALLOC;
            r_req      <= '0;
            r_off      <= '0;
            o_success  <= 1'b0;
            o_granted_offset <= '0;
            o_used_bytes <= '0;
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(NODES - 1)) r_clr <= 1'b0;
            end
            if (i_cmd.start) begin
                r_mode   <= i_mode;
                r_req    <= RW'(i_request_bytes);
                r_off    <= OW'(i_block_offset);
                r_node   <= '0;
                r_depth  <= '0;
                r_size   <= POOL_BYTES;
                r_base   <= '0;
                r_back   <= 1'b0;
                r_carry  <= 1'b0;
                r_right  <= 1'b0;
                r_ok     <= 1'b0;
                r_got    <= '0;
                r_cphase <= '0;
            end else begin
                r_node   <= n_node;
                r_depth  <= n_depth;
                r_size   <= n_size;
                r_base   <= n_base;
                r_back   <= n_back;
                r_carry  <= n_carry;
                r_right  <= n_right;
                r_ok     <= n_ok;
                r_got    <= n_got;
                r_used   <= n_used;
                r_cphase <= n_cphase;
            end
            if (i_cmd.chk && r_cphase == 2'd1) r_lst <= rdata;  // left child
            if (i_cmd.finish) begin
                o_success        <= r_ok;
                o_granted_offset <= 16'(r_got);
                o_used_bytes     <= r_used;
            end
        end
    end

    assign o_clear_busy = r_clr;

    `ASSERT_IMPL(a_no_start_clr, i_clk, i_rst_n, i_cmd.start, !r_clr, "start during clear")
    `ASSERT_IMPL(a_grant_in_pool, i_clk, i_rst_n, i_cmd.finish && r_ok, r_got < POOL_BYTES, "grant beyond pool")
    `ASSERT_IMPL(a_size_set, i_clk, i_rst_n, i_cmd.eval || i_cmd.chk, r_size != '0, "empty node size")
endmodule
`default_nettype wire

/* src/buddy_block_allocator_top.sv */
// Top level of the buddy block allocator.
//  channel | dir | handshake            | fields
//  in      | in  | i_valid / o_stall    | i_mode, i_request_bytes, i_block_offset
//  out     | out | o_valid / i_stall    | o_success, o_granted_offset, o_used_bytes
// A node visit on the way down is a read, then an act on the read data; each return to
// a split node is one act step, and a merge check on a free reads the left child, reads
// the right child and decides. The walk length is set by the single node store read
// port, and the result is latched once the walk ends.
// After reset a clearing pass marks every node free; input is stalled meanwhile. One
// item is in work at a time; the result is held until taken.
`default_nettype none
module buddy_block_allocator_top #(
    parameter int LEVELS      = 6,
    parameter int BLOCK_BYTES = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_mode,
    input  wire logic [23:0] i_request_bytes,
    input  wire logic [15:0] i_block_offset,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_success,
    output logic [15:0]      o_granted_offset,
    output logic [16:0]      o_used_bytes
);
    import bba_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic clear_busy;

    bba_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall(i_stall),
        .i_clear_busy(clear_busy), .i_sts(sts), .o_cmd(cmd), .o_stall(o_stall),
        .o_valid(o_valid)
    );

    bba_dp #(.LEVELS(LEVELS), .BLOCK_BYTES(BLOCK_BYTES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_mode(i_mode),
        .i_request_bytes(i_request_bytes), .i_block_offset(i_block_offset),
        .o_sts(sts), .o_clear_busy(clear_busy), .o_success(o_success),
        .o_granted_offset(o_granted_offset), .o_used_bytes(o_used_bytes)
    );
endmodule
`default_nettype wire

/* sim/tb_buddy_block_allocator_top.sv */
// Testbench for the buddy block allocator: directed and random alloc/free traffic.
`timescale 1ns / 1ps
`default_nettype none
module tb_buddy_block_allocator_top;
    import bba_pkg::*;

    localparam int LEVELS      = 6;
    localparam int BLOCK_BYTES = 1024;
    localparam int NODES       = (2 << LEVELS) - 1;
    localparam int POOL_BYTES  = BLOCK_BYTES << LEVELS;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic        success;
        logic [15:0] granted_offset;
        logic [16:0] used_bytes;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_mode = MODE_ALLOC;
    logic [23:0] i_request_bytes = '0;
    logic [15:0] i_block_offset = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_success;
    logic [15:0] o_granted_offset;
    logic [16:0] o_used_bytes;

    buddy_block_allocator_top #(.LEVELS(LEVELS), .BLOCK_BYTES(BLOCK_BYTES)) DUT (.*);

    always #5 i_clk = ~i_clk;

    logic [1:0]  tree_state [NODES];
    logic [16:0] pool_used;
    t_result     expected_q [$];
    int          held_offsets [$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          cycles = 0;
    bit          failed = 0;

    function automatic longint node_bytes(int depth);
        return longint'(BLOCK_BYTES) << (LEVELS - depth);
    endfunction

    function automatic bit carve(int n, int depth, longint base, longint req,
                                 ref longint got);
        longint sz;
        sz = node_bytes(depth);
        if (tree_state[n] == ST_SPLIT && depth < LEVELS) begin
            if (carve(2*n+1, depth+1, base, req, got)) return 1;
            return carve(2*n+2, depth+1, base + sz/2, req, got);
        end
        if (tree_state[n] != ST_FREE || req > sz) return 0;
        if (depth >= LEVELS || req > sz/2) begin
            tree_state[n] = ST_ALLOC;
            pool_used = pool_used + 17'(sz);
            got = base;
            return 1;
        end
        tree_state[n] = ST_SPLIT;
        return carve(2*n+1, depth+1, base, req, got);
    endfunction

    function automatic bit release_at(int n, int depth, longint base, longint off);
        longint sz;
        bit done;
        sz = node_bytes(depth);
        if (tree_state[n] == ST_FREE) return 0;
        if (tree_state[n] == ST_SPLIT && depth < LEVELS) begin
            done = release_at(2*n+1, depth+1, base, off);
            if (!done) done = release_at(2*n+2, depth+1, base + sz/2, off);
            if (tree_state[2*n+1] == ST_FREE && tree_state[2*n+2] == ST_FREE)
                tree_state[n] = ST_FREE;
            return done;
        end
        if (base == off) begin
            tree_state[n] = ST_FREE;
            pool_used = pool_used - 17'(sz);
            return 1;
        end
        return 0;
    endfunction

    function automatic void predict_allocator(logic mode, logic [23:0] req,
                                              logic [15:0] off);
        t_result r;
        longint got;
        got = 0;
        if (mode == MODE_ALLOC) begin
            r.success = carve(0, 0, 0, longint'(req), got);
            if (!r.success) got = 0;
            else held_offsets.push_back(int'(got));
        end else begin
            r.success = release_at(0, 0, 0, longint'(off));
            got = 0;
        end
        r.granted_offset = got[15:0];
        r.used_bytes = pool_used;
        expected_q.push_back(r);
    endfunction

    // valid stays high after the accepting edge; the next call or drain() moves it
    task automatic send_item(logic mode, logic [23:0] req, logic [15:0] off);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_request_bytes <= req;
        i_block_offset <= off;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_allocator(mode, req, off);
    endtask

    task automatic send_alloc(logic [23:0] req);
        send_item(MODE_ALLOC, req, 16'($urandom));
    endtask

    task automatic send_free(logic [15:0] off);
        send_item(MODE_FREE, 24'($urandom), off);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() > 0) @(posedge i_clk);
    endtask

    // receiver side: random stall, compare each taken result
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        i_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                $error("result with nothing expected");
                failed = 1;
            end else begin
                t_result e;
                e = expected_q.pop_front();
                if (o_success !== e.success) begin
                    $error("success: expected %0d, got %0d", e.success, o_success);
                    failed = 1;
                end
                if (o_granted_offset !== e.granted_offset) begin
                    $error("granted_offset: expected %0d, got %0d",
                           e.granted_offset, o_granted_offset);
                    failed = 1;
                end
                if (o_used_bytes !== e.used_bytes) begin
                    $error("used_bytes: expected %0d, got %0d", e.used_bytes, o_used_bytes);
                    failed = 1;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic test_field_extremes();
        send_alloc(24'd0);                       // zero takes one smallest block
        send_alloc(24'hFFFFFF);                  // above the pool: fails
        send_alloc(24'(POOL_BYTES + 1));
        send_alloc(24'(BLOCK_BYTES));
        send_alloc(24'(BLOCK_BYTES + 1));
        send_free(16'hFFFF);                     // nothing there
        send_free(16'(BLOCK_BYTES));             // second smallest block
        send_free(16'd0);
        send_free(16'd0);                        // double free
        send_free(16'(2 * BLOCK_BYTES));
        send_free(16'(BLOCK_BYTES));
        drain();
    endtask

    task automatic test_full_pool();
        send_alloc(24'(POOL_BYTES));             // whole pool
        send_alloc(24'd1);                       // pool full
        send_free(16'd0);
        for (int i = 0; i < (1 << LEVELS); i++) send_alloc(24'($urandom_range(BLOCK_BYTES)));
        send_alloc(24'd5);                       // full of smallest blocks
        for (int i = 0; i < (1 << LEVELS); i += 2) send_free(16'(i * BLOCK_BYTES));
        send_alloc(24'(2 * BLOCK_BYTES));        // fragmented: fails
        for (int i = 1; i < (1 << LEVELS); i += 2) send_free(16'(i * BLOCK_BYTES));
        held_offsets.delete();
        drain();
    endtask

    task automatic test_random_traffic(int count);
        int k, sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            if (sel < 45) begin
                k = $urandom_range(LEVELS);
                send_alloc(24'($urandom_range(BLOCK_BYTES << k)));
            end else if (sel < 85 && held_offsets.size() > 0) begin
                k = $urandom_range(held_offsets.size() - 1);
                send_free(16'(held_offsets[k]));
                held_offsets.delete(k);
            end else if (sel < 92) begin
                send_alloc(24'($urandom));
            end else begin
                send_free(16'($urandom));
            end
        end
        drain();
    endtask

    initial begin
        pool_used = '0;
        foreach (tree_state[i]) tree_state[i] = ST_FREE;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_field_extremes();
        test_full_pool();
        send_idle_pct = 20; recv_idle_pct = 53;
        test_random_traffic(120);
        send_idle_pct = 53; recv_idle_pct = 20;
        test_random_traffic(120);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random_traffic(130);
        repeat (500) @(posedge i_clk);
        if (!failed && expected_q.size() == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
